// File: design/recursive_gaussian_line_filter_defines.svh
// ----------------------------------------------------------------------------
// Recursive Gaussian line filter - assertion macros
// Shared checks on clk with disable on arst_n.
// ----------------------------------------------------------------------------
`ifndef RECURSIVE_GAUSSIAN_LINE_FILTER_DEFINES_SVH
`define RECURSIVE_GAUSSIAN_LINE_FILTER_DEFINES_SVH

// same-cycle implication
`define RGLF_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication
`define RGLF_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// File: design/rglf_pkg.sv
// ----------------------------------------------------------------------------
// rglf_pkg
// Constants, command type and arithmetic helpers of the line filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rglf_pkg;

	localparam int MAX_LINE = 64;
	localparam int IDX_W    = $clog2(MAX_LINE);

	localparam int X_W    = 16;            // sample width
	localparam int W_W    = 24;            // Q15.8 intermediates
	localparam int COEF_W = 20;            // Q3.16 coefficients
	localparam int PROD_W = COEF_W + W_W;
	localparam int ACC_W  = PROD_W + 2;
	localparam int SH_W   = ACC_W - 16;

	localparam logic [1:0] REG_GAIN_B    = 2'd0;
	localparam logic [1:0] REG_FEEDBACK1 = 2'd1;
	localparam logic [1:0] REG_FEEDBACK2 = 2'd2;
	localparam logic [1:0] REG_FEEDBACK3 = 2'd3;

	localparam logic signed [COEF_W-1:0] GAIN_B_RESET = COEF_W'(65536);

	localparam logic [1:0] SEL_GAIN = 2'd0;
	localparam logic [1:0] SEL_H0   = 2'd1;
	localparam logic [1:0] SEL_H1   = 2'd2;
	localparam logic [1:0] SEL_H2   = 2'd3;

	typedef struct packed {
		logic             take;      // item accepted this cycle
		logic             seed_f;    // first sample of a line
		logic             mode_b;    // anti-causal pass
		logic [1:0]       mul_sel;
		logic             mul_first;
		logic             acc_en;
		logic             commit;    // write result and shift history
		logic             seed_b;    // seed backward history from result
		logic [IDX_W-1:0] addr;
		logic             frd;
		logic             brd;
		logic             out_load;
		logic             out_last;
	} rglf_cmd_t;

	typedef struct packed {
		logic out_free;
	} rglf_sts_t;

	// (acc >>> 16) saturated to 24 bits; rounding constant already in acc
	function automatic logic signed [W_W-1:0] sat_w(input logic signed [ACC_W-1:0] acc);
		logic signed [SH_W-1:0] sh;
		logic [SH_W-W_W:0]      top;
		logic signed [W_W-1:0]  r;
		sh  = acc[ACC_W-1:16];
		top = sh[SH_W-1:W_W-1];
		if ((&top) || !(|top))
			r = sh[W_W-1:0];
		else if (sh[SH_W-1])
			r = {1'b1, {(W_W-1){1'b0}}};
		else
			r = {1'b0, {(W_W-1){1'b1}}};
		return r;
	endfunction

	function automatic logic signed [X_W-1:0] to_out(input logic signed [W_W-1:0] c);
		logic signed [W_W:0] s;
		logic [X_W:0]        t;
		logic signed [X_W-1:0] r;
		s = {c[W_W-1], c} + (W_W+1)'(128);
		t = s[W_W:8];
		if (t[X_W] == t[X_W-1])
			r = t[X_W-1:0];
		else if (t[X_W])
			r = {1'b1, {(X_W-1){1'b0}}};
		else
			r = {1'b0, {(X_W-1){1'b1}}};
		return r;
	endfunction

endpackage

`default_nettype wire

// File: design/rglf_ctrl.sv
// ----------------------------------------------------------------------------
// rglf_ctrl
// Sequencer: forward step per item, backward sweep and emit at line end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rglf_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  s_tvalid,
	input  wire                  s_tlast,
	output logic                 s_tready,
	input  rglf_pkg::rglf_sts_t  sts,
	output rglf_pkg::rglf_cmd_t  cmd
);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_MUL    = 7'b0000010,
		S_DRAIN  = 7'b0000100,
		S_COMMIT = 7'b0001000,
		S_BRD    = 7'b0010000,
		S_ERD    = 7'b0100000,
		S_ELD    = 7'b1000000
	} rglf_state_t;

	rglf_state_t                  state_q;
	logic [1:0]                   phase_q;
	logic                         bwd_q;
	logic                         end_q;
	logic [rglf_pkg::IDX_W-1:0]   cnt_q;
	logic [rglf_pkg::IDX_W-1:0]   idx_q;
	logic [rglf_pkg::IDX_W-1:0]   last_q;
	logic                         line_done;

	assign s_tready  = (state_q == S_IDLE);
	assign line_done = end_q || (cnt_q == rglf_pkg::IDX_W'(rglf_pkg::MAX_LINE - 1));

	always_comb begin
		cmd           = '0;
		cmd.mode_b    = bwd_q;
		cmd.addr      = bwd_q ? idx_q : cnt_q;
		cmd.mul_sel   = phase_q;
		case (state_q)
			S_IDLE: begin
				cmd.take   = s_tvalid;
				cmd.seed_f = (cnt_q == '0);
			end
			S_MUL: begin
				cmd.mul_first = (phase_q == 2'd0);
				cmd.acc_en    = (phase_q != 2'd0);
			end
			S_DRAIN: cmd.acc_en = 1'b1;
			S_COMMIT: begin
				cmd.commit = 1'b1;
				cmd.seed_b = !bwd_q && line_done;
			end
			S_BRD: cmd.frd = 1'b1;
			S_ERD: cmd.brd = 1'b1;
			S_ELD: begin
				cmd.out_load = sts.out_free;
				cmd.out_last = (idx_q == last_q);
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= '0;
			bwd_q   <= 1'b0;
			end_q   <= 1'b0;
			cnt_q   <= '0;
			idx_q   <= '0;
			last_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						end_q   <= s_tlast;
						bwd_q   <= 1'b0;
						phase_q <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					phase_q <= phase_q + 2'd1;
					if (phase_q == 2'd3)
						state_q <= S_DRAIN;
				end
				S_DRAIN: state_q <= S_COMMIT;
				S_COMMIT: begin
					if (!bwd_q) begin
						if (line_done) begin
							last_q  <= cnt_q;
							idx_q   <= cnt_q;
							cnt_q   <= '0;
							bwd_q   <= 1'b1;
							state_q <= S_BRD;
						end else begin
							cnt_q   <= cnt_q + 1'b1;
							state_q <= S_IDLE;
						end
					end else if (idx_q == '0) begin
						state_q <= S_ERD;
					end else begin
						idx_q   <= idx_q - 1'b1;
						state_q <= S_BRD;
					end
				end
				S_BRD: begin
					phase_q <= '0;
					state_q <= S_MUL;
				end
				S_ERD: state_q <= S_ELD;
				S_ELD: begin
					if (sts.out_free) begin
						if (idx_q == last_q) begin
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_ERD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: design/rglf_datapath.sv
// ----------------------------------------------------------------------------
// rglf_datapath
// Coefficients, shared multiply-accumulate, histories, line stores, output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rglf_datapath (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_we,
	input  wire  [1:0]                   cfg_index,
	input  wire  [rglf_pkg::COEF_W-1:0]  cfg_data,
	input  wire  [rglf_pkg::X_W-1:0]     s_tdata,
	output logic                         m_tvalid,
	input  wire                          m_tready,
	output logic [rglf_pkg::X_W-1:0]     m_tdata,
	output logic                         m_tlast,
	input  rglf_pkg::rglf_cmd_t          cmd,
	output rglf_pkg::rglf_sts_t          sts
);

	logic signed [rglf_pkg::COEF_W-1:0] gain_q, fb1_q, fb2_q, fb3_q;
	logic signed [rglf_pkg::W_W-1:0]    x_q;
	logic signed [rglf_pkg::W_W-1:0]    fh_q [3];
	logic signed [rglf_pkg::W_W-1:0]    bh_q [3];
	logic signed [rglf_pkg::W_W-1:0]    fwd_mem [rglf_pkg::MAX_LINE];
	logic signed [rglf_pkg::W_W-1:0]    bwd_mem [rglf_pkg::MAX_LINE];
	logic signed [rglf_pkg::W_W-1:0]    f_rd_q;
	logic signed [rglf_pkg::W_W-1:0]    b_rd_q;
	logic signed [rglf_pkg::PROD_W-1:0] mul_s1;
	logic signed [rglf_pkg::ACC_W-1:0]  acc_q;
	logic signed [rglf_pkg::COEF_W-1:0] coef_sel;
	logic signed [rglf_pkg::W_W-1:0]    op_sel;
	logic signed [rglf_pkg::W_W-1:0]    res;
	logic signed [rglf_pkg::W_W-1:0]    h0, h1, h2;
	logic                               m_tvalid_q;
	logic [rglf_pkg::X_W-1:0]           m_tdata_q;
	logic                               m_tlast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= rglf_pkg::GAIN_B_RESET;
			fb1_q  <= '0;
			fb2_q  <= '0;
			fb3_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				rglf_pkg::REG_GAIN_B:    gain_q <= cfg_data;
				rglf_pkg::REG_FEEDBACK1: fb1_q  <= cfg_data;
				rglf_pkg::REG_FEEDBACK2: fb2_q  <= cfg_data;
				rglf_pkg::REG_FEEDBACK3: fb3_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign h0  = cmd.mode_b ? bh_q[0] : fh_q[0];
	assign h1  = cmd.mode_b ? bh_q[1] : fh_q[1];
	assign h2  = cmd.mode_b ? bh_q[2] : fh_q[2];
	assign res = rglf_pkg::sat_w(acc_q);

	always_comb begin
		case (cmd.mul_sel)
			rglf_pkg::SEL_GAIN: begin
				coef_sel = gain_q;
				op_sel   = cmd.mode_b ? f_rd_q : x_q;
			end
			rglf_pkg::SEL_H0: begin
				coef_sel = fb1_q;
				op_sel   = h0;
			end
			rglf_pkg::SEL_H1: begin
				coef_sel = fb2_q;
				op_sel   = h1;
			end
			rglf_pkg::SEL_H2: begin
				coef_sel = fb3_q;
				op_sel   = h2;
			end
			default: begin
				coef_sel = '0;
				op_sel   = '0;
			end
		endcase
	end

	// one product per cycle, registered before it is accumulated; acc starts at the rounding half
	always_ff @(posedge clk) begin
		mul_s1 <= coef_sel * op_sel;
		if (cmd.mul_first)
			acc_q <= rglf_pkg::ACC_W'(32768);
		else if (cmd.acc_en)
			acc_q <= acc_q + rglf_pkg::ACC_W'(mul_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fh_q <= '{default: '0};
			bh_q <= '{default: '0};
		end else begin
			if (cmd.take && cmd.seed_f)
				fh_q <= '{default: {s_tdata, 8'h00}};
			else if (cmd.commit && !cmd.mode_b)
				fh_q <= '{res, fh_q[0], fh_q[1]};
			if (cmd.commit && cmd.seed_b)
				bh_q <= '{default: res};
			else if (cmd.commit && cmd.mode_b)
				bh_q <= '{res, bh_q[0], bh_q[1]};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take)
			x_q <= {s_tdata, 8'h00};
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && !cmd.mode_b)
			fwd_mem[cmd.addr] <= res;
		if (cmd.frd)
			f_rd_q <= fwd_mem[cmd.addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && cmd.mode_b)
			bwd_mem[cmd.addr] <= res;
		if (cmd.brd)
			b_rd_q <= bwd_mem[cmd.addr];
	end

	assign sts.out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (cmd.out_load)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_tdata_q <= rglf_pkg::to_out(b_rd_q);
			m_tlast_q <= cmd.out_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

`default_nettype wire

// File: design/recursive_gaussian_line_filter.sv
// ----------------------------------------------------------------------------
// recursive_gaussian_line_filter
// Third-order recursive Gaussian over one line of up to 64 signed samples.
// ----------------------------------------------------------------------------
// Items arrive one sample each, tlast on the last of a line (a line is cut
// after 64 samples). Each accepted item then runs its causal step:
// one shared 20x24 multiplier takes the four products in turn, then a drain
// and a write-back. At the end of a line the anti-causal pass runs over the
// forward store sample by sample, then the line is emitted in original
// order, each sample read from the backward store and loaded while the output
// is free. No input is taken during the backward pass and emit; the
// last output may still wait while the next line starts.
`timescale 1ns / 1ps
`default_nettype none

`include "recursive_gaussian_line_filter_defines.svh"

module recursive_gaussian_line_filter (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_tvalid,
	output logic                         s_tready,
	input  wire  [rglf_pkg::X_W-1:0]     s_tdata,   // sample_in
	input  wire                          s_tlast,   // line_end
	output logic                         m_tvalid,
	input  wire                          m_tready,
	output logic [rglf_pkg::X_W-1:0]     m_tdata,   // sample_out
	output logic                         m_tlast,   // last_out
	input  wire                          cfg_we,
	input  wire  [1:0]                   cfg_index,
	input  wire  [rglf_pkg::COEF_W-1:0]  cfg_data
);

	rglf_pkg::rglf_cmd_t cmd;
	rglf_pkg::rglf_sts_t sts;

	rglf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rglf_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cmd       (cmd),
		.sts       (sts)
	);

	`RGLF_ASSERT_IMP(a_load_when_free, cmd.out_load, sts.out_free)
	`RGLF_ASSERT_NXT(a_busy_after_take, cmd.take, !s_tready)
	`RGLF_ASSERT_NXT(a_seed_starts_bwd, cmd.commit && cmd.seed_b, cmd.mode_b && !s_tready)
	`RGLF_ASSERT_IMP(a_no_take_in_bwd, cmd.mode_b && !s_tready, !cmd.take)

endmodule

`default_nettype wire

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the recursive Gaussian line filter. Lines of signed
// samples are streamed in under several coefficient sets, and every filtered
// item is checked against a directed table value or a bit-exact model of
// the causal and anti-causal passes kept in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	localparam int FWD = 0;
	localparam int BWD = 1;
	localparam longint W_MAX = 8388607;
	localparam longint W_MIN = -8388608;
	localparam int DIR_ROWS = 22;
	localparam int RAND_PHASES = 5;
	localparam int PHASE_ITEMS = 36;

	typedef enum logic [2:0] {KEEP, SAT_HI, SAT_LO, SMOOTH} coef_set_e;
	typedef enum int {RX_FREE, RX_MOSTLY, RX_HALF, RX_SPARSE} rx_mode_e;

	typedef struct packed {
		logic [rglf_pkg::X_W-1:0] smp;
		logic                     eol;
		logic                     typed;
		logic [rglf_pkg::X_W-1:0] want;
		coef_set_e                regs;
	} row_t;

	typedef struct packed {
		logic [rglf_pkg::X_W-1:0] smp;
		logic                     last;
	} out_item_t;

	// identity filter after reset, so typed rows there read straight through
	localparam row_t DIR_TABLE [DIR_ROWS] = '{
		'{16'h7FFF, 1'b1, 1'b1, 16'h7FFF, KEEP},
		'{16'h8000, 1'b1, 1'b1, 16'h8000, KEEP},
		'{16'h0000, 1'b1, 1'b1, 16'h0000, KEEP},
		'{16'hFFFF, 1'b1, 1'b1, 16'hFFFF, KEEP},
		'{16'h1234, 1'b0, 1'b1, 16'h1234, KEEP},
		'{16'hA5A5, 1'b0, 1'b1, 16'hA5A5, KEEP},
		'{16'h5A5A, 1'b0, 1'b1, 16'h5A5A, KEEP},
		'{16'h8001, 1'b1, 1'b1, 16'h8001, KEEP},
		'{16'h7FFF, 1'b1, 1'b1, 16'h7FFF, SAT_HI},
		'{16'h8000, 1'b1, 1'b1, 16'h8000, KEEP},
		'{16'h7FFF, 1'b0, 1'b0, 16'h0000, KEEP},
		'{16'h8000, 1'b0, 1'b0, 16'h0000, KEEP},
		'{16'h0001, 1'b1, 1'b0, 16'h0000, KEEP},
		'{16'h7FFF, 1'b1, 1'b0, 16'h0000, SAT_LO},
		'{16'h8000, 1'b0, 1'b0, 16'h0000, KEEP},
		'{16'h7FFF, 1'b0, 1'b0, 16'h0000, KEEP},
		'{16'hFFFF, 1'b1, 1'b0, 16'h0000, KEEP},
		'{16'h4000, 1'b0, 1'b0, 16'h0000, SMOOTH},
		'{16'hC000, 1'b0, 1'b0, 16'h0000, KEEP},
		'{16'h0100, 1'b0, 1'b0, 16'h0000, KEEP},
		'{16'h0000, 1'b0, 1'b0, 16'h0000, KEEP},
		'{16'h7FFF, 1'b1, 1'b0, 16'h0000, KEEP}
	};

	logic                          clk;
	logic                          arst_n;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [rglf_pkg::X_W-1:0]      s_tdata;
	logic                          s_tlast;
	logic                          m_tvalid;
	logic                          m_tready;
	logic [rglf_pkg::X_W-1:0]      m_tdata;
	logic                          m_tlast;
	logic                          cfg_we;
	logic [1:0]                    cfg_index;
	logic [rglf_pkg::COEF_W-1:0]   cfg_data;

	logic signed [rglf_pkg::COEF_W-1:0] coef [4];
	logic signed [rglf_pkg::W_W-1:0]    hist [2][3];
	logic signed [rglf_pkg::W_W-1:0]    fwd_line [rglf_pkg::MAX_LINE];
	int                                 line_len = 0;
	logic [rglf_pkg::X_W-1:0]           typed_line [$];
	logic                               line_typed = 1'b1;
	out_item_t                          filtered_q [$];
	int                                 mismatch_count = 0;
	int                                 burst_left = 0;
	bit                                 hold_req = 1'b0;

	recursive_gaussian_line_filter u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),      // sample_in
		.s_tlast   (s_tlast),      // line_end
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),      // sample_out
		.m_tlast   (m_tlast),      // last_out
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic logic signed [rglf_pkg::W_W-1:0] sat24(input longint v);
		if (v > W_MAX)
			return W_MAX[rglf_pkg::W_W-1:0];
		if (v < W_MIN)
			return W_MIN[rglf_pkg::W_W-1:0];
		return v[rglf_pkg::W_W-1:0];
	endfunction

	function automatic logic [rglf_pkg::X_W-1:0] to_out16(
			input logic signed [rglf_pkg::W_W-1:0] c);
		longint r;
		r = (longint'(c) + 128) >>> 8;
		if (r > 32767)
			r = 32767;
		if (r < -32768)
			r = -32768;
		return r[rglf_pkg::X_W-1:0];
	endfunction

	// one recursive multiply-accumulate on pass p, history shifted afterwards
	function automatic logic signed [rglf_pkg::W_W-1:0] mac_step(
			input logic signed [rglf_pkg::W_W-1:0] x, input int p);
		longint acc;
		acc = longint'(coef[rglf_pkg::REG_GAIN_B]) * longint'(x)
			+ longint'(coef[rglf_pkg::REG_FEEDBACK1]) * longint'(hist[p][0])
			+ longint'(coef[rglf_pkg::REG_FEEDBACK2]) * longint'(hist[p][1])
			+ longint'(coef[rglf_pkg::REG_FEEDBACK3]) * longint'(hist[p][2]);
		acc = (acc + 32768) >>> 16;
		hist[p][2] = hist[p][1];
		hist[p][1] = hist[p][0];
		hist[p][0] = sat24(acc);
		return hist[p][0];
	endfunction

	function automatic void filter_sample(input logic [rglf_pkg::X_W-1:0] smp,
			input logic eol);
		logic signed [rglf_pkg::W_W-1:0] xq;
		logic signed [rglf_pkg::W_W-1:0] back_line [rglf_pkg::MAX_LINE];
		out_item_t                       item;
		int                              n;
		xq = {smp, 8'h00};
		if (line_len == 0)
			for (int i = 0; i < 3; i++)
				hist[FWD][i] = xq;
		fwd_line[line_len] = mac_step(xq, FWD);
		line_len++;
		if (!eol && line_len < rglf_pkg::MAX_LINE)
			return;
		n = line_len;
		for (int i = 0; i < 3; i++)
			hist[BWD][i] = fwd_line[n-1];
		for (int k = n - 1; k >= 0; k--)
			back_line[k] = mac_step(fwd_line[k], BWD);
		for (int k = 0; k < n; k++) begin
			item.smp  = line_typed ? typed_line[k] : to_out16(back_line[k]);
			item.last = (k == n - 1);
			filtered_q.push_back(item);
		end
		line_len = 0;
		typed_line.delete();
		line_typed = 1'b1;
	endfunction

	task automatic send_sample(input logic [rglf_pkg::X_W-1:0] smp, input logic eol,
			input logic typed, input logic [rglf_pkg::X_W-1:0] want);
		s_tvalid <= 1'b1;
		s_tdata  <= smp;
		s_tlast  <= eol;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		typed_line.push_back(want);
		line_typed &= typed;
		filter_sample(smp, eol);
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8))
				@(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
		end
	endtask

	// registers only change once the block has drained
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (filtered_q.size() != 0)
			@(posedge clk);
		repeat (40)
			@(posedge clk);
	endtask

	task automatic load_coefs(input logic [rglf_pkg::COEF_W-1:0] g,
			input logic [rglf_pkg::COEF_W-1:0] f1,
			input logic [rglf_pkg::COEF_W-1:0] f2,
			input logic [rglf_pkg::COEF_W-1:0] f3);
		logic [rglf_pkg::COEF_W-1:0] v [4];
		v[rglf_pkg::REG_GAIN_B]    = g;
		v[rglf_pkg::REG_FEEDBACK1] = f1;
		v[rglf_pkg::REG_FEEDBACK2] = f2;
		v[rglf_pkg::REG_FEEDBACK3] = f3;
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= 2'(i);
			cfg_data  <= v[i];
			coef[i]    = v[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// receiver: stall pattern of its own, plus one long hold-off on request
	initial begin
		int       seg_left;
		int       hold_left;
		rx_mode_e mode;
		m_tready  = 1'b0;
		seg_left  = 0;
		hold_left = 0;
		mode      = RX_FREE;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_left = 500;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				if (seg_left == 0) begin
					mode     = rx_mode_e'($urandom_range(0, 3));
					seg_left = $urandom_range(20, 150);
				end
				seg_left--;
				case (mode)
				RX_FREE: begin
					m_tready <= 1'b1;
				end
				RX_MOSTLY: begin
					m_tready <= ($urandom_range(0, 3) != 0);
				end
				RX_HALF: begin
					m_tready <= $urandom_range(0, 1);
				end
				default: begin
					m_tready <= ($urandom_range(0, 7) == 0);
				end
				endcase
			end
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (filtered_q.size() == 0) begin
				$display("%0t: unexpected item, expected none, got sample_out %0d last_out %0b",
					$time, $signed(m_tdata), m_tlast);
				mismatch_count++;
			end else begin
				want = filtered_q.pop_front();
				if (m_tdata !== want.smp) begin
					$display("%0t: sample_out expected %0d got %0d", $time,
						$signed(want.smp), $signed(m_tdata));
					mismatch_count++;
				end
				if (m_tlast !== want.last) begin
					$display("%0t: last_out expected %0b got %0b", $time, want.last, m_tlast);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		row_t row;
		int   len;
		int   sent;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tlast   = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		coef[rglf_pkg::REG_GAIN_B]    = rglf_pkg::GAIN_B_RESET;
		coef[rglf_pkg::REG_FEEDBACK1] = '0;
		coef[rglf_pkg::REG_FEEDBACK2] = '0;
		coef[rglf_pkg::REG_FEEDBACK3] = '0;
		for (int i = 0; i < 3; i++) begin
			hist[FWD][i] = '0;
			hist[BWD][i] = '0;
		end
		burst_left = $urandom_range(1, 12);
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			row = DIR_TABLE[i];
			if (row.regs != KEEP) begin
				wait_idle();
				case (row.regs)
				SAT_HI: begin
					load_coefs(20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF);
				end
				SAT_LO: begin
					load_coefs(20'h80000, 20'h80000, 20'h80000, 20'h80000);
				end
				default: begin
					load_coefs(20'(6554), 20'(91750), 20'(-39322), 20'(6554));
				end
				endcase
			end
			send_sample(row.smp, row.eol, row.typed, row.want);
		end

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			wait_idle();
			if (ph == 0 || $urandom_range(0, 2) == 0)
				load_coefs(20'($urandom), 20'($urandom), 20'($urandom), 20'($urandom));
			else
				load_coefs(20'($urandom_range(0, 131072)), 20'($urandom_range(0, 131072)),
					20'(-$signed($urandom_range(0, 65536))), 20'($urandom_range(0, 16384)));
			if (ph == 1) begin
				hold_req   = 1'b1;
				burst_left = 200;
			end
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				// full-length lines, and lines cut at the maximum without tlast
				if (sent == 0 && ph == 2)
					len = rglf_pkg::MAX_LINE + $urandom_range(1, 5);
				else if (sent == 0 && ph == 3)
					len = rglf_pkg::MAX_LINE;
				else
					len = $urandom_range(1, 10);
				for (int j = 0; j < len; j++)
					send_sample(rglf_pkg::X_W'($urandom), j == len - 1, 1'b0, '0);
				sent += len;
			end
		end

		s_tvalid <= 1'b0;
		while (filtered_q.size() != 0)
			@(posedge clk);
		repeat (50)
			@(posedge clk);
		if (mismatch_count == 0 && filtered_q.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
